>>> rtl/dd_pkg.sv
`timescale 1ns / 1ps

package dd_pkg;

	// sizing
	localparam int NUM_PROCESSES = 8;
	localparam int NUM_RESOURCES = 4;
	localparam int COUNT_WIDTH   = 8;

	// fixed field widths
	localparam int ACTION_W   = 3;
	localparam int PROCESS_W  = 3;
	localparam int RESOURCE_W = 2;
	localparam int VALUE_W    = 8;
	localparam int MASK_W     = 8;

	localparam int PROC_AW = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
	localparam int RES_AW  = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
	localparam int WORK_W  = COUNT_WIDTH + 4;
	localparam int SUM_W   = ((COUNT_WIDTH > VALUE_W) ? COUNT_WIDTH : VALUE_W) + 1;
	localparam int ROW_W   = NUM_RESOURCES * COUNT_WIDTH;
	localparam int DEAD_W  = MASK_W + NUM_PROCESSES;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	// action codes
	localparam logic [ACTION_W-1:0] ACT_ALLOC  = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_REQ    = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_AVAIL  = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_ADD    = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_DETECT = 3'd4;

	typedef logic [NUM_RESOURCES-1:0][COUNT_WIDTH-1:0] row_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MERGE,
		S_SWEEP
	} state_t;

	// row memory access from the controller
	typedef struct packed {
		logic [PROC_AW-1:0] raddr;
		logic               alloc_we;
		logic               req_we;
		logic [PROC_AW-1:0] waddr;
		row_t               wdata;
	} ram_req_t;

	// finished detection
	typedef struct packed {
		logic              vld;
		logic [MASK_W-1:0] mask;
		logic              any;
	} result_t;

	// saturate a widened count at the count maximum
	function automatic logic [COUNT_WIDTH-1:0] clamp_count(input logic [SUM_W-1:0] v);
		if (v > SUM_W'(COUNT_MAX))
			return COUNT_MAX;
		return v[COUNT_WIDTH-1:0];
	endfunction

endpackage

>>> rtl/dd_ram.sv
`timescale 1ns / 1ps

module dd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/dd_ctrl.sv
`timescale 1ns / 1ps

module dd_ctrl
	import dd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [ACTION_W-1:0]   action,
	input  logic [PROCESS_W-1:0]  process,
	input  logic [RESOURCE_W-1:0] resource,
	input  logic [VALUE_W-1:0]    value,
	input  logic                  slot_free,
	input  row_t                  alloc_rdata,
	input  row_t                  req_rdata,
	output ram_req_t              ram_req,
	output result_t               result
);

	state_t state_q, state_nx;

	logic [ACTION_W-1:0]    op_q;
	logic [RES_AW-1:0]      res_q;
	logic [VALUE_W-1:0]     val_q;
	logic [PROC_AW-1:0]     wp_q;
	logic [NUM_PROCESSES-1:0] alloc_vld_q, req_vld_q;
	logic [COUNT_WIDTH-1:0] avail_q [NUM_RESOURCES];
	logic [WORK_W-1:0]      work_q [NUM_RESOURCES];
	logic [WORK_W-1:0]      work_nx [NUM_RESOURCES];
	logic [NUM_PROCESSES-1:0] finish_q;
	logic                   found_q;
	logic [PROC_AW-1:0]     issue_p_q;
	logic                   evl_vld_s1;
	logic [PROC_AW-1:0]     evl_p_s1;
	logic                   avld_s1, rvld_s1;

	logic accept, proc_ok, res_ok;
	row_t alloc_row, req_row, merge_row;
	logic fits, last_p, done;
	logic [WORK_W:0] wsum;
	logic [DEAD_W-1:0] dead_ext;

	function automatic logic last_issue(input logic [PROC_AW-1:0] p);
		return p == PROC_AW'(NUM_PROCESSES - 1);
	endfunction

	assign accept  = in_valid && in_ready;
	assign proc_ok = int'(process) < NUM_PROCESSES;
	assign res_ok  = int'(resource) < NUM_RESOURCES;

	// rows as read, never-written rows read as zero
	assign alloc_row = avld_s1 ? alloc_rdata : '0;
	assign req_row   = rvld_s1 ? req_rdata : '0;

	// row check and release for the process under evaluation
	always_comb begin
		fits = evl_vld_s1 && !finish_q[evl_p_s1];
		for (int r = 0; r < NUM_RESOURCES; r++) begin
			if (WORK_W'(req_row[r]) > work_q[r])
				fits = 1'b0;
			wsum = (WORK_W + 1)'(work_q[r]) + (WORK_W + 1)'(alloc_row[r]);
			work_nx[r] = wsum[WORK_W] ? '1 : wsum[WORK_W-1:0];
		end
	end

	assign last_p = evl_p_s1 == PROC_AW'(NUM_PROCESSES - 1);
	assign done   = (state_q == S_SWEEP) && evl_vld_s1 && last_p && !found_q && !fits;

	// single element update of the row read in the previous cycle
	always_comb begin
		merge_row = (op_q == ACT_ALLOC) ? alloc_row : req_row;
		case (op_q)
			ACT_ADD:
				merge_row[res_q] = clamp_count(SUM_W'(req_row[res_q]) + SUM_W'(val_q));
			default:
				merge_row[res_q] = clamp_count(SUM_W'(val_q));
		endcase
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (action) inside
						ACT_ALLOC, ACT_REQ, ACT_ADD:
							if (proc_ok && res_ok)
								state_nx = S_MERGE;
						ACT_DETECT:
							state_nx = S_SWEEP;
						default: ;
					endcase
				end
			end
			S_MERGE:
				state_nx = S_IDLE;
			S_SWEEP:
				if (done)
					state_nx = S_IDLE;
			default:
				state_nx = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready         = (state_q == S_IDLE) && slot_free;
		ram_req.raddr    = (state_q == S_SWEEP) ? issue_p_q : PROC_AW'(process);
		ram_req.waddr    = wp_q;
		ram_req.wdata    = merge_row;
		ram_req.alloc_we = (state_q == S_MERGE) && (op_q == ACT_ALLOC);
		ram_req.req_we   = (state_q == S_MERGE) && (op_q != ACT_ALLOC);
	end

	assign dead_ext      = DEAD_W'(~finish_q);
	assign result.vld    = done;
	assign result.mask   = dead_ext[MASK_W-1:0];
	assign result.any    = |(~finish_q);

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			alloc_vld_q <= '0;
			req_vld_q   <= '0;
			finish_q    <= '0;
			found_q     <= 1'b0;
			issue_p_q   <= '0;
			evl_vld_s1  <= 1'b0;
			for (int r = 0; r < NUM_RESOURCES; r++) begin
				avail_q[r] <= '0;
				work_q[r]  <= '0;
			end
		end else begin
			state_q <= state_nx;
			if (ram_req.alloc_we)
				alloc_vld_q[wp_q] <= 1'b1;
			if (ram_req.req_we)
				req_vld_q[wp_q] <= 1'b1;

			unique case (state_q)
				S_IDLE: begin
					evl_vld_s1 <= 1'b0;
					if (accept && action == ACT_AVAIL && res_ok)
						avail_q[RES_AW'(resource)] <= clamp_count(SUM_W'(value));
					if (accept && action == ACT_DETECT) begin
						for (int r = 0; r < NUM_RESOURCES; r++)
							work_q[r] <= WORK_W'(avail_q[r]);
						finish_q  <= '0;
						found_q   <= 1'b0;
						issue_p_q <= '0;
					end
				end
				S_SWEEP: begin
					// issue the next row read every cycle, round robin
					issue_p_q  <= last_issue(issue_p_q) ? '0 : issue_p_q + 1'b1;
					evl_vld_s1 <= !done;
					if (fits) begin
						for (int r = 0; r < NUM_RESOURCES; r++)
							work_q[r] <= work_nx[r];
						finish_q[evl_p_s1] <= 1'b1;
					end
					if (evl_vld_s1)
						found_q <= last_p ? 1'b0 : (found_q || fits);
				end
				default: ;
			endcase
		end
	end

	// payload and read pipeline registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= action;
			res_q <= RES_AW'(resource);
			val_q <= value;
			wp_q  <= PROC_AW'(process);
		end
		evl_p_s1 <= ram_req.raddr;
		avld_s1  <= alloc_vld_q[ram_req.raddr];
		rvld_s1  <= req_vld_q[ram_req.raddr];
	end

	// checks
	a_done_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		result.vld |-> (state_q == S_SWEEP && evl_vld_s1 && last_p))
		else $error("result raised outside the final row of a sweep");

	a_merge_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MERGE) |-> $past(state_q == S_IDLE && accept))
		else $error("row merge without an accepted word");

	a_finish_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP && $past(state_q == S_SWEEP))
			|-> ((finish_q & $past(finish_q)) == $past(finish_q)))
		else $error("finish mark cleared during detection");

	a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP) |-> !(ram_req.alloc_we || ram_req.req_we))
		else $error("row write during detection");

endmodule

>>> rtl/deadlock_detector_top.sv
`timescale 1ns / 1ps

// Channel   Handshake               Fields
// in        in_valid / in_ready     action, process, resource, value
// out       out_valid / out_ready   deadlocked_mask, any_deadlock
//
// Write-available words complete in the idle state; allocation, request and
// add words also pass through a merge state (row read, merge and write back).
// Detect runs sweeps over all process rows, at most NUM_PROCESSES + 1 of them:
// one row is checked per cycle, set by the work vector update each check needs.
// Reset clears all stores at once through per-row valid bits; no clearing pass.
// Input is held off while a detect is running, during a row merge, and while an
// undelivered result sits in the output register.

module deadlock_detector_top
	import dd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [ACTION_W-1:0]   action,
	input  logic [PROCESS_W-1:0]  process,
	input  logic [RESOURCE_W-1:0] resource,
	input  logic [VALUE_W-1:0]    value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [MASK_W-1:0]     deadlocked_mask,
	output logic                  any_deadlock
);

	ram_req_t ram_req;
	result_t  result;
	row_t     alloc_rdata, req_rdata;
	logic     out_valid_q;
	logic     slot_free;

	assign slot_free = !out_valid_q || out_ready;

	// allocation rows
	dd_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NUM_PROCESSES)
	) u_alloc_ram (
		.clk   (clk),
		.we    (ram_req.alloc_we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (alloc_rdata)
	);

	// request rows
	dd_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NUM_PROCESSES)
	) u_req_ram (
		.clk   (clk),
		.we    (ram_req.req_we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (req_rdata)
	);

	dd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.process     (process),
		.resource    (resource),
		.value       (value),
		.slot_free   (slot_free),
		.alloc_rdata (alloc_rdata),
		.req_rdata   (req_rdata),
		.ram_req     (ram_req),
		.result      (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result.vld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result.vld) begin
			deadlocked_mask <= result.mask;
			any_deadlock    <= result.any;
		end
	end

	assign out_valid = out_valid_q;

endmodule
